// ===== design/stpw_pkg.sv =====
// ----------------------------------------------------------------------------
// stpw_pkg: shared types, constants and helpers
// Formats, lookup constants and elaboration-time helpers for the
// scan point to world transform pipeline.
// ----------------------------------------------------------------------------
package stpw_pkg;

   // Defaults for top-level parameters
   localparam int SCAN_POINTS_DEF   = 180;
   localparam int IR_BITS_DEF       = 12;
   localparam int CORDIC_STAGES_DEF = 16;

   // Field widths
   localparam int RAW_W  = 12;
   localparam int ANG_W  = 8;
   localparam int OUT_W  = 17;
   localparam int CSR_W  = 16;
   localparam int IDX_W  = 3;

   // Datapath formats
   localparam int M_W     = 31;   // Q30 mantissa in [1, 2)
   localparam int FRAC_W  = 16;   // log2 fraction bits
   localparam int LOGN_W  = 4;    // log2 integer part
   localparam int XY_W    = 26;   // signed Q8 CORDIC lengths
   localparam int Z_W     = 34;   // signed binary angle accumulator

   localparam logic [19:0] LOG2_A_Q16 = 20'd866582;
   localparam logic [16:0] INV_EXP_Q16 = 17'd120086;
   localparam logic signed [30:0] CORDIC_INV_GAIN = 31'sd652032874;

   // Heading conversion constants
   localparam logic [16:0] HEAD_TURN  = 17'd36000;
   localparam logic [29:0] HEAD_HALF  = 30'd18000;
   localparam logic [16:0] HEAD_STEP  = 17'd119304;    // 2^32 / 36000, whole part
   localparam logic [14:0] HEAD_REM   = 15'd23296;     // 2^32 mod 36000
   localparam logic [25:0] HEAD_RECIP = 26'd61083980;  // ceil(2^36 / 1125)

   // Register indexes
   typedef enum logic [IDX_W-1:0] {
      CSR_POSE_X      = 3'd0,
      CSR_POSE_Y      = 3'd1,
      CSR_HEADING     = 3'd2,
      CSR_RANGE_LIMIT = 3'd3,
      CSR_RADIAL      = 3'd4,
      CSR_AXIAL       = 3'd5
   } csr_index_type;

   // CORDIC arctangent table, 2^32 per turn
   localparam logic [31:0] ATAN_TAB [24] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   // Truncated integer square root, used for constants only
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bit_m;
      logic [63:0] rem;
      res   = 64'd0;
      bit_m = 64'h4000_0000_0000_0000;
      rem   = v;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bit_m) begin
            rem = rem - (res + bit_m);
            res = (res >> 1) + bit_m;
         end else begin
            res = res >> 1;
         end
         bit_m = bit_m >> 2;
      end
      return res;
   endfunction

   // Q30 root 2^(2^-k), built by repeated truncated square roots
   function automatic logic [63:0] root_q30(input int k);
      logic [63:0] r;
      r = 64'h8000_0000;
      for (int j = 1; j <= 16; j++) begin
         if (j <= k) begin
            r = isqrt64(r << 30);
         end
      end
      return r;
   endfunction

   // Whole degrees to binary angle, rounded
   function automatic logic [31:0] scan_bam(input int a);
      logic [63:0] num;
      num = (64'(a) << 32) + 64'd180;
      return 32'(num / 64'd360);
   endfunction

endpackage

// ===== design/stpw_log_cell.sv =====
// ----------------------------------------------------------------------------
// stpw_log_cell: one bit of the log2 fraction
// Squares the Q30 mantissa, renormalizes and shifts one fraction bit in.
// ----------------------------------------------------------------------------
module stpw_log_cell
   import stpw_pkg::*;
#(
   parameter int SIDE_W = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   input  logic [M_W-1:0]    up_m,
   input  logic [FRAC_W-1:0] up_frac,
   input  logic [SIDE_W-1:0] up_side,
   output logic              dn_valid,
   output logic [M_W-1:0]    dn_m,
   output logic [FRAC_W-1:0] dn_frac,
   output logic [SIDE_W-1:0] dn_side
);

   logic [2*M_W-1:0]  sq;
   logic [M_W:0]      sq_hi;
   logic              valid_ff;
   logic [M_W-1:0]    m_ff, m_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic [SIDE_W-1:0] side_ff;

   // Square and renormalize into [1, 2)
   always_comb begin
      sq      = up_m * up_m;
      sq_hi   = sq[2*M_W-1:M_W-1];
      m_in    = sq_hi[M_W] ? sq_hi[M_W:1] : sq_hi[M_W-1:0];
      frac_in = {up_frac[FRAC_W-2:0], sq_hi[M_W]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
      m_ff    <= m_in;
      frac_ff <= frac_in;
      side_ff <= up_side;
   end

   assign dn_valid = valid_ff;
   assign dn_m     = m_ff;
   assign dn_frac  = frac_ff;
   assign dn_side  = side_ff;

endmodule

// ===== design/stpw_pow_cell.sv =====
// ----------------------------------------------------------------------------
// stpw_pow_cell: one bit of 2^frac
// Multiplies the Q30 product by the root 2^(2^-K) when fraction bit is set.
// ----------------------------------------------------------------------------
module stpw_pow_cell
   import stpw_pkg::*;
#(
   parameter int K      = 1,
   parameter int SIDE_W = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   input  logic [M_W-1:0]    up_m,
   input  logic [FRAC_W-1:0] up_f,
   input  logic [SIDE_W-1:0] up_side,
   output logic              dn_valid,
   output logic [M_W-1:0]    dn_m,
   output logic [FRAC_W-1:0] dn_f,
   output logic [SIDE_W-1:0] dn_side
);

   localparam logic [M_W-1:0] ROOT = M_W'(root_q30(K));

   logic [2*M_W-1:0]  prod;
   logic              valid_ff;
   logic [M_W-1:0]    m_ff, m_in;
   logic [FRAC_W-1:0] f_ff;
   logic [SIDE_W-1:0] side_ff;

   // Apply the root for this fraction bit
   always_comb begin
      prod = up_m * ROOT;
      m_in = up_f[FRAC_W-K] ? prod[2*M_W-2:M_W-1] : up_m;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
      m_ff    <= m_in;
      f_ff    <= up_f;
      side_ff <= up_side;
   end

   assign dn_valid = valid_ff;
   assign dn_m     = m_ff;
   assign dn_f     = f_ff;
   assign dn_side  = side_ff;

endmodule

// ===== design/stpw_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// stpw_cordic_cell: one CORDIC rotation step
// Rotates by +/- atan(2^-K) toward zero residual angle.
// ----------------------------------------------------------------------------
module stpw_cordic_cell
   import stpw_pkg::*;
#(
   parameter int K      = 0,
   parameter int SIDE_W = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   input  logic signed [XY_W-1:0]  up_x,
   input  logic signed [XY_W-1:0]  up_y,
   input  logic signed [Z_W-1:0]   up_z,
   input  logic [SIDE_W-1:0]       up_side,
   output logic                    dn_valid,
   output logic signed [XY_W-1:0]  dn_x,
   output logic signed [XY_W-1:0]  dn_y,
   output logic signed [Z_W-1:0]   dn_z,
   output logic [SIDE_W-1:0]       dn_side
);

   localparam logic signed [Z_W-1:0] ATAN = Z_W'(ATAN_TAB[K]);

   logic signed [XY_W-1:0] sx, sy;
   logic                   valid_ff;
   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]  z_ff, z_in;
   logic [SIDE_W-1:0]      side_ff;

   // Step the rotation toward the residual sign
   always_comb begin
      sx = up_x >>> K;
      sy = up_y >>> K;
      if (!up_z[Z_W-1]) begin
         x_in = up_x - sy;
         y_in = up_y + sx;
         z_in = up_z - ATAN;
      end else begin
         x_in = up_x + sy;
         y_in = up_y - sx;
         z_in = up_z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      side_ff <= up_side;
   end

   assign dn_valid = valid_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;
   assign dn_z     = z_ff;
   assign dn_side  = side_ff;

endmodule

// ===== design/scan_point_to_world_transform_top.sv =====
// ----------------------------------------------------------------------------
// scan_point_to_world_transform_top: scan sample to world point
// Range from the infrared reading, beam to Cartesian, heading rotation
// and pose offset, as one cell pipeline.
// ----------------------------------------------------------------------------
//  channel | ports                         | handshake
//  --------+-------------------------------+------------------------------
//  request | req_scan_angle, req_raw_ir    | start high and busy low
//  result  | rsp_world_x/y_mm, angle_echo  | rsp_valid strobe, one cycle
//  config  | csr_index, csr_wdata          | csr_wr_en, taken at once
//
// One word enters per cycle while busy is low; a word passes the input stage,
// the 16 log cells, 16 power cells and two CORDIC chains before it leaves.
// A heading write starts a binary angle conversion by reciprocal
// multiplication; busy is high during it. Dropped samples give no strobe.
// Synchronous reset clears the pipeline valids and loads register defaults.
// The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module scan_point_to_world_transform_top
   import stpw_pkg::*;
#(
   parameter int SCAN_POINTS   = SCAN_POINTS_DEF,
   parameter int IR_BITS       = IR_BITS_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [ANG_W-1:0]        req_scan_angle,
   input  logic [RAW_W-1:0]        req_raw_ir,
   input  logic                    csr_wr_en,
   input  logic [IDX_W-1:0]        csr_index,
   input  logic [CSR_W-1:0]        csr_wdata,
   output logic                    rsp_valid,
   output logic signed [OUT_W-1:0] rsp_world_x_mm,
   output logic signed [OUT_W-1:0] rsp_world_y_mm,
   output logic [ANG_W-1:0]        rsp_angle_echo
);

   localparam logic [RAW_W-1:0] RAW_MASK = (IR_BITS >= RAW_W) ? {RAW_W{1'b1}} :
                                           RAW_W'((1 << IR_BITS) - 1);
   localparam int LSIDE_W = LOGN_W + ANG_W;
   localparam int PSIDE_W = 3 + ANG_W;

   // ---------------- configuration registers ----------------
   typedef enum logic [1:0] {
      HD_IDLE,
      HD_SPLIT,
      HD_SCALE
   } hd_state_type;

   logic signed [15:0] pose_x_ff, pose_y_ff;
   logic [9:0]         limit_ff;
   logic [7:0]         radial_ff, axial_ff;
   logic [31:0]        head_bam_ff;
   hd_state_type       hd_state_ff;
   logic [15:0]        head_ff;
   logic [24:0]        hd_y_ff;
   logic [31:0]        hd_base_ff;
   logic               head_wr;
   logic [15:0]        head_mod;
   logic [29:0]        hd_x;
   logic [31:0]        hd_whole;
   logic [50:0]        hd_prod;

   // Reduce heading and form the reciprocal products
   always_comb begin
      head_wr  = csr_wr_en && (csr_index == CSR_HEADING);
      head_mod = ({1'b0, csr_wdata} >= HEAD_TURN) ?
                 16'({1'b0, csr_wdata} - HEAD_TURN) : csr_wdata;
      hd_x     = 30'(head_ff) * 30'(HEAD_REM) + HEAD_HALF;
      hd_whole = 32'(33'(head_ff) * 33'(HEAD_STEP));
      hd_prod  = 51'(hd_y_ff) * 51'(HEAD_RECIP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pose_x_ff   <= 16'sd0;
         pose_y_ff   <= 16'sd0;
         limit_ff    <= 10'd500;
         radial_ff   <= 8'd45;
         axial_ff    <= 8'd110;
         head_bam_ff <= 32'd0;
         hd_state_ff <= HD_IDLE;
         head_ff     <= 16'd0;
         hd_y_ff     <= 25'd0;
         hd_base_ff  <= 32'd0;
      end else begin
         // start a heading conversion, else advance the one running
         if (head_wr) begin
            head_ff     <= head_mod;
            hd_state_ff <= HD_SPLIT;
         end else begin
            case (hd_state_ff)
               HD_SPLIT: begin
                  hd_y_ff     <= hd_x[29:5];
                  hd_base_ff  <= hd_whole;
                  hd_state_ff <= HD_SCALE;
               end
               HD_SCALE: begin
                  head_bam_ff <= hd_base_ff + {17'd0, hd_prod[50:36]};
                  hd_state_ff <= HD_IDLE;
               end
               default: ;
            endcase
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_POSE_X:      pose_x_ff <= csr_wdata;
               CSR_POSE_Y:      pose_y_ff <= csr_wdata;
               CSR_HEADING:     ;
               CSR_RANGE_LIMIT: limit_ff  <= csr_wdata[9:0];
               CSR_RADIAL:      radial_ff <= csr_wdata[7:0];
               CSR_AXIAL:       axial_ff  <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
   end

   assign busy = (hd_state_ff != HD_IDLE);

   // ---------------- scan angle table ----------------
   logic [31:0] scan_tab [256];
   for (genvar g = 0; g < 256; g++) begin : g_scan
      assign scan_tab[g] = scan_bam(g);
   end

   // ---------------- input stage ----------------
   logic [RAW_W-1:0]  raw;
   logic [LOGN_W-1:0] msb;
   logic [M_W-1:0]    m0;
   logic              s0_ok;
   logic              s0_valid_ff;
   logic [M_W-1:0]    s0_m_ff;
   logic [LSIDE_W-1:0] s0_side_ff;

   // Normalize the reading into [1, 2)
   always_comb begin
      raw = req_raw_ir & RAW_MASK;
      msb = '0;
      for (int i = 0; i < RAW_W; i++) begin
         if (raw[i]) begin
            msb = LOGN_W'(i);
         end
      end
      m0    = M_W'(M_W'(raw) << (5'd30 - 5'(msb)));
      s0_ok = (raw != '0) && ({1'b0, req_scan_angle} < 9'(SCAN_POINTS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start && !busy && s0_ok;
      end
      s0_m_ff    <= m0;
      s0_side_ff <= {msb, req_scan_angle};
   end

   // ---------------- log2 chain ----------------
   logic               lg_valid [0:FRAC_W];
   logic [M_W-1:0]     lg_m     [0:FRAC_W];
   logic [FRAC_W-1:0]  lg_frac  [0:FRAC_W];
   logic [LSIDE_W-1:0] lg_side  [0:FRAC_W];

   assign lg_valid[0] = s0_valid_ff;
   assign lg_m[0]     = s0_m_ff;
   assign lg_frac[0]  = '0;
   assign lg_side[0]  = s0_side_ff;

   for (genvar i = 0; i < FRAC_W; i++) begin : g_log
      stpw_log_cell #(.SIDE_W(LSIDE_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (lg_valid[i]),
         .up_m     (lg_m[i]),
         .up_frac  (lg_frac[i]),
         .up_side  (lg_side[i]),
         .dn_valid (lg_valid[i+1]),
         .dn_m     (lg_m[i+1]),
         .dn_frac  (lg_frac[i+1]),
         .dn_side  (lg_side[i+1])
      );
   end

   // ---------------- exponent stages ----------------
   logic              e1_valid_ff;
   logic [19:0]       e1_d_ff;
   logic [ANG_W-1:0]  e1_angle_ff;
   logic [36:0]       e_prod;
   logic [20:0]       e_val;
   logic              e2_valid_ff;
   logic [2:0]        e2_ip_ff;
   logic [FRAC_W-1:0] e2_f_ff;
   logic [ANG_W-1:0]  e2_angle_ff;

   assign e_prod = e1_d_ff * INV_EXP_Q16;
   assign e_val  = e_prod[36:16];

   // Form the exponent; drop ranges of 1280 mm and beyond
   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
         e2_valid_ff <= 1'b0;
      end else begin
         e1_valid_ff <= lg_valid[FRAC_W];
         e2_valid_ff <= e1_valid_ff && (e_val[20:16] < 5'd7);
      end
      e1_d_ff     <= LOG2_A_Q16 - {lg_side[FRAC_W][LSIDE_W-1:ANG_W], lg_frac[FRAC_W]};
      e1_angle_ff <= lg_side[FRAC_W][ANG_W-1:0];
      e2_ip_ff    <= e_val[18:16];
      e2_f_ff     <= e_val[15:0];
      e2_angle_ff <= e1_angle_ff;
   end

   // ---------------- power chain ----------------
   logic               pw_valid [0:FRAC_W];
   logic [M_W-1:0]     pw_m     [0:FRAC_W];
   logic [FRAC_W-1:0]  pw_f     [0:FRAC_W];
   logic [PSIDE_W-1:0] pw_side  [0:FRAC_W];

   assign pw_valid[0] = e2_valid_ff;
   assign pw_m[0]     = {1'b1, {(M_W-1){1'b0}}};
   assign pw_f[0]     = e2_f_ff;
   assign pw_side[0]  = {e2_ip_ff, e2_angle_ff};

   for (genvar i = 0; i < FRAC_W; i++) begin : g_pow
      stpw_pow_cell #(.K(i + 1), .SIDE_W(PSIDE_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (pw_valid[i]),
         .up_m     (pw_m[i]),
         .up_f     (pw_f[i]),
         .up_side  (pw_side[i]),
         .dn_valid (pw_valid[i+1]),
         .dn_m     (pw_m[i+1]),
         .dn_f     (pw_f[i+1]),
         .dn_side  (pw_side[i+1])
      );
   end

   // ---------------- range stages ----------------
   logic [M_W+11:0]   total;
   logic [4:0]        rng_sh;
   logic              r1_valid_ff;
   logic [18:0]       r1_r_ff;
   logic [ANG_W-1:0]  r1_angle_ff;
   logic [31:0]       a1;
   logic              q1;
   logic signed [XY_W-1:0] x0;

   // Scale by 10 mm in Q8 and apply the integer exponent
   always_comb begin
      total  = (43'(pw_m[FRAC_W]) << 11) + (43'(pw_m[FRAC_W]) << 9);
      rng_sh = 5'd30 - 5'(pw_side[FRAC_W][PSIDE_W-1:ANG_W]);
   end

   // Pre-rotate the beam into the CORDIC range
   always_comb begin
      a1 = scan_tab[r1_angle_ff];
      q1 = a1[31] ^ a1[30];
      x0 = XY_W'(r1_r_ff) + XY_W'({radial_ff, 8'd0});
      if (q1) begin
         x0 = -x0;
         a1 = {~a1[31], a1[30:0]};
      end
   end

   logic               c1_valid [0:CORDIC_STAGES];
   logic signed [XY_W-1:0] c1_x [0:CORDIC_STAGES];
   logic signed [XY_W-1:0] c1_y [0:CORDIC_STAGES];
   logic signed [Z_W-1:0]  c1_z [0:CORDIC_STAGES];
   logic [ANG_W-1:0]   c1_side  [0:CORDIC_STAGES];
   logic               r2_valid_ff;
   logic signed [XY_W-1:0] r2_x_ff;
   logic signed [Z_W-1:0]  r2_z_ff;
   logic [ANG_W-1:0]   r2_angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_valid_ff <= 1'b0;
         r2_valid_ff <= 1'b0;
      end else begin
         r1_valid_ff <= pw_valid[FRAC_W];
         r2_valid_ff <= r1_valid_ff && (r1_r_ff < 19'({limit_ff, 8'd0}));
      end
      r1_r_ff     <= 19'(total >> rng_sh);
      r1_angle_ff <= pw_side[FRAC_W][ANG_W-1:0];
      r2_x_ff     <= x0;
      r2_z_ff     <= Z_W'(signed'(a1));
      r2_angle_ff <= r1_angle_ff;
   end

   // ---------------- beam rotation chain ----------------
   assign c1_valid[0] = r2_valid_ff;
   assign c1_x[0]     = r2_x_ff;
   assign c1_y[0]     = '0;
   assign c1_z[0]     = r2_z_ff;
   assign c1_side[0]  = r2_angle_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot1
      stpw_cordic_cell #(.K(i), .SIDE_W(ANG_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (c1_valid[i]),
         .up_x     (c1_x[i]),
         .up_y     (c1_y[i]),
         .up_z     (c1_z[i]),
         .up_side  (c1_side[i]),
         .dn_valid (c1_valid[i+1]),
         .dn_x     (c1_x[i+1]),
         .dn_y     (c1_y[i+1]),
         .dn_z     (c1_z[i+1]),
         .dn_side  (c1_side[i+1])
      );
   end

   // ---------------- gain, axial offset, heading pre-rotation ----------------
   localparam int P_W = XY_W + 31;
   localparam logic signed [P_W-1:0] HALF_Q30 = P_W'(64'd536870912);

   logic signed [P_W-1:0]  g1_px, g1_py;
   logic                   g1_valid_ff;
   logic signed [XY_W-1:0] g1_x_ff, g1_y_ff;
   logic [ANG_W-1:0]       g1_angle_ff;

   assign g1_px = c1_x[CORDIC_STAGES] * CORDIC_INV_GAIN + HALF_Q30;
   assign g1_py = c1_y[CORDIC_STAGES] * CORDIC_INV_GAIN + HALF_Q30;

   logic [31:0]            a2;
   logic                   q2;
   logic signed [XY_W-1:0] wx0, wy0;

   // Swap axes and pre-rotate by the heading
   always_comb begin
      a2  = head_bam_ff;
      q2  = a2[31] ^ a2[30];
      wx0 = g1_y_ff;
      wy0 = g1_x_ff;
      if (q2) begin
         wx0 = -wx0;
         wy0 = -wy0;
         a2  = {~a2[31], a2[30:0]};
      end
   end

   logic                   p2_valid_ff;
   logic signed [XY_W-1:0] p2_x_ff, p2_y_ff;
   logic signed [Z_W-1:0]  p2_z_ff;
   logic [ANG_W-1:0]       p2_angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         g1_valid_ff <= c1_valid[CORDIC_STAGES];
         p2_valid_ff <= g1_valid_ff;
      end
      g1_x_ff     <= XY_W'(g1_px >>> 30);
      g1_y_ff     <= XY_W'(g1_py >>> 30) + XY_W'({axial_ff, 8'd0});
      g1_angle_ff <= c1_side[CORDIC_STAGES];
      p2_x_ff     <= wx0;
      p2_y_ff     <= wy0;
      p2_z_ff     <= Z_W'(signed'(a2));
      p2_angle_ff <= g1_angle_ff;
   end

   // ---------------- heading rotation chain ----------------
   logic               c2_valid [0:CORDIC_STAGES];
   logic signed [XY_W-1:0] c2_x [0:CORDIC_STAGES];
   logic signed [XY_W-1:0] c2_y [0:CORDIC_STAGES];
   logic signed [Z_W-1:0]  c2_z [0:CORDIC_STAGES];
   logic [ANG_W-1:0]   c2_side  [0:CORDIC_STAGES];

   assign c2_valid[0] = p2_valid_ff;
   assign c2_x[0]     = p2_x_ff;
   assign c2_y[0]     = p2_y_ff;
   assign c2_z[0]     = p2_z_ff;
   assign c2_side[0]  = p2_angle_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot2
      stpw_cordic_cell #(.K(i), .SIDE_W(ANG_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (c2_valid[i]),
         .up_x     (c2_x[i]),
         .up_y     (c2_y[i]),
         .up_z     (c2_z[i]),
         .up_side  (c2_side[i]),
         .dn_valid (c2_valid[i+1]),
         .dn_x     (c2_x[i+1]),
         .dn_y     (c2_y[i+1]),
         .dn_z     (c2_z[i+1]),
         .dn_side  (c2_side[i+1])
      );
   end

   // ---------------- gain, rounding, pose ----------------
   logic signed [P_W-1:0]  g2_px, g2_py;
   logic                   g2_valid_ff;
   logic signed [XY_W-1:0] g2_x_ff, g2_y_ff;
   logic [ANG_W-1:0]       g2_angle_ff;
   logic signed [XY_W-1:0] rx, ry;
   logic signed [OUT_W:0]  wx_sum, wy_sum;

   assign g2_px = c2_x[CORDIC_STAGES] * CORDIC_INV_GAIN + HALF_Q30;
   assign g2_py = c2_y[CORDIC_STAGES] * CORDIC_INV_GAIN + HALF_Q30;

   // Round Q8 to mm and add the pose
   always_comb begin
      rx     = (g2_x_ff + XY_W'(128)) >>> 8;
      ry     = (g2_y_ff + XY_W'(128)) >>> 8;
      wx_sum = (OUT_W+1)'(rx) + (OUT_W+1)'(pose_x_ff);
      wy_sum = (OUT_W+1)'(ry) + (OUT_W+1)'(pose_y_ff);
   end

   logic                   out_valid_ff;
   logic signed [OUT_W-1:0] out_x_ff, out_y_ff;
   logic [ANG_W-1:0]       out_angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         g2_valid_ff  <= c2_valid[CORDIC_STAGES];
         out_valid_ff <= g2_valid_ff;
      end
      g2_x_ff      <= XY_W'(g2_px >>> 30);
      g2_y_ff      <= XY_W'(g2_py >>> 30);
      g2_angle_ff  <= c2_side[CORDIC_STAGES];
      out_x_ff     <= wx_sum[OUT_W-1:0];
      out_y_ff     <= wy_sum[OUT_W-1:0];
      out_angle_ff <= g2_angle_ff;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_world_x_mm = out_x_ff;
   assign rsp_world_y_mm = out_y_ff;
   assign rsp_angle_echo = out_angle_ff;

endmodule

// ===== design/stpw_checker.sv =====
// ----------------------------------------------------------------------------
// stpw_checker: port-level checks
// Watches reset behavior, heading conversion busy and result angles.
// ----------------------------------------------------------------------------
module stpw_checker
   import stpw_pkg::*;
#(
   parameter int SCAN_POINTS = SCAN_POINTS_DEF
) (
   input logic             clock,
   input logic             reset,
   input logic             busy,
   input logic             csr_wr_en,
   input logic [IDX_W-1:0] csr_index,
   input logic             rsp_valid,
   input logic [ANG_W-1:0] rsp_angle_echo
);

   // No word leaves right after reset
   a_reset_quiet : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word right after reset");

   // Reset stops the heading conversion
   a_reset_idle : assert property (@(posedge clock) reset |=> !busy)
      else $error("busy right after reset");

   // A heading write starts the conversion
   a_head_busy : assert property (@(posedge clock) disable iff (reset)
      (csr_wr_en && csr_index == CSR_HEADING) |=> busy)
      else $error("heading write did not raise busy");

   // Only scan angles leave the block
   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_angle_echo} < 9'(SCAN_POINTS)))
      else $error("result angle outside the scan");

endmodule

bind scan_point_to_world_transform_top stpw_checker #(.SCAN_POINTS(SCAN_POINTS)) u_stpw_checker (
   .clock          (clock),
   .reset          (reset),
   .busy           (busy),
   .csr_wr_en      (csr_wr_en),
   .csr_index      (csr_index),
   .rsp_valid      (rsp_valid),
   .rsp_angle_echo (rsp_angle_echo)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: scan point to world transform testbench
// Drives scan samples through the command port and register writes through
// the CSR port. Every accepted word is run through a fixed-point predictor,
// and each strobed point is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
   import stpw_pkg::*;

   localparam int LATENCY     = 41 + 2 * CORDIC_STAGES_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RAND_PHASES = 9;
   localparam int PHASE_WORDS = 222;
   localparam longint INV_GAIN = 64'sd652032874;
   localparam longint LOG2_A   = 64'sd866582;
   localparam longint INV_EXP  = 64'sd120086;

   typedef struct {
      logic [OUT_W-1:0] wx;
      logic [OUT_W-1:0] wy;
      logic [ANG_W-1:0] ang;
   } point_t;

   typedef struct {
      logic [ANG_W-1:0] ang;
      logic [RAW_W-1:0] raw;
      bit               drop;   // known at a glance to give no point
   } sample_t;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [ANG_W-1:0]        req_scan_angle;
   logic [RAW_W-1:0]        req_raw_ir;
   logic                    csr_wr_en;
   logic [IDX_W-1:0]        csr_index;
   logic [CSR_W-1:0]        csr_wdata;
   logic                    rsp_valid;
   logic signed [OUT_W-1:0] rsp_world_x_mm;
   logic signed [OUT_W-1:0] rsp_world_y_mm;
   logic [ANG_W-1:0]        rsp_angle_echo;

   // Predictor copy of the registers
   longint      pose_x;
   longint      pose_y;
   bit [15:0]   heading;
   bit [9:0]    range_limit;
   bit [7:0]    radial_off;
   bit [7:0]    axial_off;

   longint unsigned half_roots [1:16];
   point_t      pending_points [$];
   int          errors;
   int          words_sent;
   int          points_seen;
   int          cycles;
   int          idle_pct;

   scan_point_to_world_transform_top u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_scan_angle (req_scan_angle),
      .req_raw_ir     (req_raw_ir),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_world_x_mm (rsp_world_x_mm),
      .rsp_world_y_mm (rsp_world_y_mm),
      .rsp_angle_echo (rsp_angle_echo)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Q16 log2 by repeated squaring of the normalized mantissa
   function automatic longint log2_fix(int unsigned v);
      int n;
      longint unsigned m;
      longint frac;
      n = 0;
      frac = 0;
      while (n < 31 && (v >> (n + 1)) != 0) n++;
      m = longint'(v) << (30 - n);
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      return longint'(n) * 65536 + frac;
   endfunction

   // Q8 range in mm, -1 when always out of reach
   function automatic longint range_fix(int unsigned raw);
      longint e;
      longint ip;
      longint unsigned m;
      longint unsigned total;
      e = ((LOG2_A - log2_fix(raw)) * INV_EXP) >>> 16;
      if (e >= 7 * 65536) return -1;
      if (e < -24 * 65536) return 0;
      ip = e >>> 16;
      m = 64'd1 << 30;
      for (int k = 1; k <= 16; k++) begin
         if (e[16 - k]) m = (m * half_roots[k]) >> 30;
      end
      total = 64'd2560 * m;
      if (ip >= 0) return longint'((total << ip) >> 30);
      return longint'(total >> (30 - ip));
   endfunction

   task automatic turn_vector(inout longint x, inout longint y, input bit [31:0] ang);
      longint z;
      longint nx;
      if (ang >= 32'h4000_0000 && ang < 32'hC000_0000) begin
         x = -x;
         y = -y;
         ang = ang - 32'h8000_0000;
      end
      z = longint'($signed(ang));
      for (int k = 0; k < CORDIC_STAGES_DEF; k++) begin
         if (z >= 0) begin
            nx = x - (y >>> k);
            y = y + (x >>> k);
            z = z - longint'(ATAN_TAB[k]);
         end else begin
            nx = x + (y >>> k);
            y = y - (x >>> k);
            z = z + longint'(ATAN_TAB[k]);
         end
         x = nx;
      end
      x = (x * INV_GAIN + (64'sd1 <<< 29)) >>> 30;
      y = (y * INV_GAIN + (64'sd1 <<< 29)) >>> 30;
   endtask

   // Work out the world point a sample gives, if any
   task automatic predict_point(input logic [ANG_W-1:0] ang, input logic [RAW_W-1:0] raw,
                                output bit hit, output point_t pt);
      longint r;
      longint x1;
      longint y1;
      longint wx;
      longint wy;
      bit [31:0] a_scan;
      bit [31:0] a_head;
      longint unsigned num;
      hit = 0;
      pt = '{default: '0};
      if (raw == 0 || ang >= SCAN_POINTS_DEF) return;
      r = range_fix(raw);
      if (r < 0 || r >= longint'(range_limit) * 256) return;
      num = (longint'(ang) << 32) + 180;
      a_scan = 32'(num / 360);
      num = (longint'(heading % 36000) << 32) + 18000;
      a_head = 32'(num / 36000);
      x1 = r + longint'(radial_off) * 256;
      y1 = 0;
      turn_vector(x1, y1, a_scan);
      y1 = y1 + longint'(axial_off) * 256;
      wx = y1;
      wy = x1;
      turn_vector(wx, wy, a_head);
      wx = pose_x + ((wx + 128) >>> 8);
      wy = pose_y + ((wy + 128) >>> 8);
      pt.wx = wx[OUT_W-1:0];
      pt.wy = wy[OUT_W-1:0];
      pt.ang = ang;
      hit = 1;
   endtask

   // Write one register at the next falling edge; caller stands at a falling edge
   task automatic write_reg(input csr_index_type idx, input logic [CSR_W-1:0] val);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         CSR_POSE_X:      pose_x = longint'($signed(val));
         CSR_POSE_Y:      pose_y = longint'($signed(val));
         CSR_HEADING:     heading = val;
         CSR_RANGE_LIMIT: range_limit = val[9:0];
         CSR_RADIAL:      radial_off = val[7:0];
         CSR_AXIAL:       axial_off = val[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Present one word, hold it until taken, predict on acceptance
   task automatic send_word(input logic [ANG_W-1:0] ang, input logic [RAW_W-1:0] raw,
                            input bit drop);
      bit hit;
      point_t pt;
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_scan_angle = ang;
      req_raw_ir = raw;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      predict_point(ang, raw, hit, pt);
      if (hit) pending_points.push_back(pt);
      if (drop && hit) begin
         errors++;
         if (errors <= 10)
            $display("ERROR: sample angle %0d raw %0d should give no point", ang, raw);
      end
      words_sent++;
      @(negedge clock);
   endtask

   // Let every expected point arrive, then cover dropped words still in flight
   task automatic drain;
      start = 1'b0;
      while (pending_points.size() != 0) @(negedge clock);
      repeat (LATENCY + 8) @(negedge clock);
   endtask

   // Check each strobed point against the oldest prediction
   always @(posedge clock) begin
      point_t exp_pt;
      if (!reset && rsp_valid) begin
         points_seen++;
         if (pending_points.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: unexpected point x %0d y %0d angle %0d",
                                       rsp_world_x_mm, rsp_world_y_mm, rsp_angle_echo);
         end else begin
            exp_pt = pending_points.pop_front();
            if (rsp_world_x_mm !== exp_pt.wx || rsp_world_y_mm !== exp_pt.wy ||
                rsp_angle_echo !== exp_pt.ang) begin
               errors++;
               if (errors <= 10)
                  $display("ERROR: point exp (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                           $signed(exp_pt.wx), $signed(exp_pt.wy), exp_pt.ang,
                           rsp_world_x_mm, rsp_world_y_mm, rsp_angle_echo);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      sample_t directed [$];
      logic [CSR_W-1:0] vals [6];
      reset = 1'b1;
      start = 1'b0;
      req_scan_angle = '0;
      req_raw_ir = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_POSE_X;
      csr_wdata = '0;
      errors = 0;
      words_sent = 0;
      points_seen = 0;
      cycles = 0;
      idle_pct = 0;
      pose_x = 0;
      pose_y = 0;
      heading = 0;
      range_limit = 500;
      radial_off = 45;
      axial_off = 110;
      half_roots[1] = int_sqrt((64'd1 << 31) << 30);
      for (int k = 2; k <= 16; k++) half_roots[k] = int_sqrt(half_roots[k-1] << 30);

      directed = '{
         '{8'd0,   12'd0,    1'b1},   // zero reading, infinite range
         '{8'd90,  12'd0,    1'b1},
         '{8'd180, 12'd4095, 1'b1},   // angle past the scan
         '{8'd255, 12'd2000, 1'b1},
         '{8'd0,   12'd1,    1'b0},   // far exponent
         '{8'd0,   12'd4095, 1'b0},
         '{8'd179, 12'd4095, 1'b0},
         '{8'd90,  12'd4095, 1'b0},
         '{8'd45,  12'd2048, 1'b0},
         '{8'd135, 12'd1200, 1'b0},   // near the range limit
         '{8'd30,  12'd1100, 1'b0},
         '{8'd60,  12'd1150, 1'b0},
         '{8'd85,  12'hAAA,  1'b0},
         '{8'd170, 12'h555,  1'b0},
         '{8'd1,   12'hFFE,  1'b0},
         '{8'd178, 12'h801,  1'b0},
         '{8'd120, 12'd3000, 1'b0}
      };

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed words at the reset register values
      foreach (directed[i]) send_word(directed[i].ang, directed[i].raw, directed[i].drop);
      drain();

      // Random phases, each under a new register setting
      for (int p = 0; p < RAND_PHASES; p++) begin
         idle_pct = (p < 3) ? 34 : (p < 6) ? 78 : 0;
         case (p)
            0: vals = '{16'h7FFF, 16'h7FFF, 16'd35999, 16'd1023, 16'd255, 16'd255};
            1: vals = '{16'h8000, 16'h8000, 16'd0,     16'd0,    16'd0,   16'd0};
            2: vals = '{16'h8000, 16'h7FFF, 16'hFFFF,  16'hFFFF, 16'hFF00, 16'hFFFF};
            default: vals = '{16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom_range(150, 1023)), 16'($urandom),
                              16'($urandom)};
         endcase
         for (int r = 0; r < 6; r++) write_reg(csr_index_type'(r), vals[r]);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            send_word(($urandom_range(9) == 0) ? 8'($urandom_range(180, 255))
                                                : 8'($urandom_range(0, 179)),
                      ($urandom_range(6) == 0) ? 12'($urandom)
                                                : 12'($urandom_range(1000, 4095)),
                      1'b0);
         end
         // Hold off until every point of this phase is back
         drain();
      end

      repeat (LATENCY) @(posedge clock);
      if (pending_points.size() != 0) errors++;
      $display("Sent %0d samples over %0d register settings, checked %0d world points.",
               words_sent, RAND_PHASES + 1, points_seen);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
